/* rtl/core/assert_macros.svh */
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define MCMT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same check on the block clock and reset.
`define MCMT_ASSERT(label, prop, msg) `MCMT_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

/* rtl/core/mcmt_pkg.sv */
package mcmt_pkg;

    localparam int OPCODE_W = 3;
    localparam int PIDX_W   = 6;
    localparam int KIND_W   = 2;
    localparam int CC_W     = 7;
    localparam int CHAN_W   = 5;
    localparam int DEV_W    = 4;
    localparam int STAT_W   = 8;
    localparam int DATA_W   = 7;
    localparam int RKIND_W  = 2;
    localparam int NORM_W   = 16;
    localparam int ENTRY_W  = KIND_W + CC_W + CHAN_W + DEV_W;

    localparam logic [OPCODE_W-1:0] OP_SET     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LEARN   = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_CANCEL  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_EVENT   = 3'd6;

    localparam logic [KIND_W-1:0] KIND_CC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEND  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PRESS = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [RKIND_W-1:0] RES_UPDATE = 2'd0;
    localparam logic [RKIND_W-1:0] RES_LEARN  = 2'd1;
    localparam logic [RKIND_W-1:0] RES_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_LEARN,
        S_SCAN,
        S_FLUSH
    } t_state;

    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_QUERY,
        OUT_LEARN,
        OUT_PEND_MID,
        OUT_PEND_LAST
    } t_out_sel;

    typedef struct packed {
        logic     accept;
        logic     advance;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic learn_take;
        logic out_free;
        logic hit;
        logic pend_v;
        logic scan_done;
    } t_status;

    // round(v * 65535 / 127): 65535 = 127 * 516 + 3, so the quotient is
    // 516 * v plus a small correction.
    function automatic logic [NORM_W-1:0] norm7(input logic [DATA_W-1:0] v);
        logic [8:0]        t;
        logic [NORM_W-1:0] base;
        logic [1:0]        q;
        t    = {2'b0, v} + {1'b0, v, 1'b0} + 9'd63;
        base = {v, 9'b0} + {7'b0, v, 2'b0};
        q    = (t >= 9'd381) ? 2'd3 : (t >= 9'd254) ? 2'd2 : (t >= 9'd127) ? 2'd1 : 2'd0;
        return base + {14'b0, q};
    endfunction

    // round(v * 65535 / 16383): 65535 = 16383 * 4 + 3.
    function automatic logic [NORM_W-1:0] norm14(input logic [2*DATA_W-1:0] v);
        logic [16:0]       t;
        logic [NORM_W-1:0] base;
        logic [1:0]        q;
        t    = {3'b0, v} + {2'b0, v, 1'b0} + 17'd8191;
        base = {v, 2'b0};
        q    = (t >= 17'd49149) ? 2'd3 : (t >= 17'd32766) ? 2'd2 :
               (t >= 17'd16383) ? 2'd1 : 2'd0;
        return base + {14'b0, q};
    endfunction

endpackage

/* rtl/core/midi_controller_mapping_table.sv */
// Set, remove, clear and learn control give no result. A query reads the table and loads
// the answer into the output register once the result side is free; a learned capture
// is loaded the same way from its latched event. A MIDI event scans the table through one
// read port and can wait while the result side stalls; the block takes the next item
// only after the current one is done. Reset (i_rst_n low, synchronous) empties the table,
// disarms learn and drops any pending result.
`include "assert_macros.svh"

module midi_controller_mapping_table
    import mcmt_pkg::*;
#(
    parameter int MAX_PARAMS  = 64,
    parameter int MAX_HITS    = 16,
    parameter int MAX_DEVICES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [PIDX_W-1:0]   i_param_index,
    input  logic [KIND_W-1:0]   i_map_kind,
    input  logic [CC_W-1:0]     i_map_cc_number,
    input  logic [CHAN_W-1:0]   i_map_channel,
    input  logic [DEV_W-1:0]    i_device_id,
    input  logic [STAT_W-1:0]   i_status_byte,
    input  logic [DATA_W-1:0]   i_data_one,
    input  logic [DATA_W-1:0]   i_data_two,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RKIND_W-1:0]  o_result_kind,
    output logic [PIDX_W-1:0]   o_out_param,
    output logic [NORM_W-1:0]   o_norm_value,
    output logic [KIND_W-1:0]   o_out_kind,
    output logic [CC_W-1:0]     o_out_cc_number,
    output logic [CHAN_W-1:0]   o_out_channel,
    output logic [DEV_W-1:0]    o_out_device,
    output logic                o_found,
    output logic                o_last
);

    t_cmd    cmd;
    t_status status;

    mcmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    mcmt_datapath #(
        .MAX_PARAMS  (MAX_PARAMS),
        .MAX_HITS    (MAX_HITS),
        .MAX_DEVICES (MAX_DEVICES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_param_index   (i_param_index),
        .i_map_kind      (i_map_kind),
        .i_map_cc_number (i_map_cc_number),
        .i_map_channel   (i_map_channel),
        .i_device_id     (i_device_id),
        .i_status_byte   (i_status_byte),
        .i_data_one      (i_data_one),
        .i_data_two      (i_data_two),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_out_param     (o_out_param),
        .o_norm_value    (o_norm_value),
        .o_out_kind      (o_out_kind),
        .o_out_cc_number (o_out_cc_number),
        .o_out_channel   (o_out_channel),
        .o_out_device    (o_out_device),
        .o_found         (o_found),
        .o_last          (o_last)
    );

    `MCMT_ASSERT(a_load_into_free, (cmd.out_sel != OUT_NONE) |-> status.out_free, "result loaded over an unsent item")
    `MCMT_ASSERT(a_advance_unblocked, cmd.advance |-> !(status.hit && status.pend_v && !status.out_free), "scan advanced past a blocked hit")
    `MCMT_ASSERT(a_single_is_last, (o_valid && o_result_kind != RES_UPDATE) |-> o_last, "query or capture not marked last")
    `MCMT_ASSERT(a_accept_clears_pending, cmd.accept |=> !status.pend_v, "held hit survived a new item")

endmodule

/* rtl/core/mcmt_ram.sv */
module mcmt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mcmt_datapath.sv */
module mcmt_datapath
    import mcmt_pkg::*;
#(
    parameter int MAX_PARAMS  = 64,
    parameter int MAX_HITS    = 16,
    parameter int MAX_DEVICES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [PIDX_W-1:0]   i_param_index,
    input  logic [KIND_W-1:0]   i_map_kind,
    input  logic [CC_W-1:0]     i_map_cc_number,
    input  logic [CHAN_W-1:0]   i_map_channel,
    input  logic [DEV_W-1:0]    i_device_id,
    input  logic [STAT_W-1:0]   i_status_byte,
    input  logic [DATA_W-1:0]   i_data_one,
    input  logic [DATA_W-1:0]   i_data_two,
    input  logic                i_stall,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    output logic                o_valid,
    output logic [RKIND_W-1:0]  o_result_kind,
    output logic [PIDX_W-1:0]   o_out_param,
    output logic [NORM_W-1:0]   o_norm_value,
    output logic [KIND_W-1:0]   o_out_kind,
    output logic [CC_W-1:0]     o_out_cc_number,
    output logic [CHAN_W-1:0]   o_out_channel,
    output logic [DEV_W-1:0]    o_out_device,
    output logic                o_found,
    output logic                o_last
);

    localparam int IDX_W = $clog2(MAX_PARAMS);
    localparam int CNT_W = IDX_W + 1;
    localparam int HIT_W = $clog2(MAX_HITS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_PARAMS);
    localparam logic [HIT_W-1:0] HIT_END  = HIT_W'(MAX_HITS);

    // Table and learn state
    logic [MAX_PARAMS-1:0] r_valid;
    logic                  r_learn_armed;
    logic [PIDX_W-1:0]     r_learn_target;

    // Latched item
    logic [PIDX_W-1:0] r_op_param;
    logic              r_q_ok;
    logic [KIND_W-1:0] r_ev_kind;
    logic [CHAN_W-1:0] r_ev_chan;
    logic [DATA_W-1:0] r_ev_d1;
    logic [DEV_W-1:0]  r_ev_dev;
    logic [NORM_W-1:0] r_norm;

    // Scan state
    logic [CNT_W-1:0] r_addr;
    logic             r_chk_v;
    logic [IDX_W-1:0] r_chk_idx;
    logic [HIT_W-1:0] r_hits;
    logic             r_pend_v;
    logic [IDX_W-1:0] r_pend_idx;

    // Output register
    logic               r_ovalid;
    logic [RKIND_W-1:0] r_o_rkind;
    logic [PIDX_W-1:0]  r_o_param;
    logic [NORM_W-1:0]  r_o_norm;
    logic [KIND_W-1:0]  r_o_kind;
    logic [CC_W-1:0]    r_o_cc;
    logic [CHAN_W-1:0]  r_o_chan;
    logic [DEV_W-1:0]   r_o_dev;
    logic               r_o_found;
    logic               r_o_last;

    logic [KIND_W-1:0]  w_ev_kind;
    logic [CHAN_W-1:0]  w_ev_chan;
    logic [NORM_W-1:0]  w_norm;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_wr_idx;
    logic               w_we;
    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic               w_learn_take;
    logic               w_issue;
    logic               w_match;
    logic               w_hit;
    logic               w_q_found;
    logic               w_out_free;

    logic [KIND_W-1:0] w_mk;
    logic [CC_W-1:0]   w_mc;
    logic [CHAN_W-1:0] w_mch;
    logic [DEV_W-1:0]  w_md;
    logic              w_dev_ok;
    logic              w_chan_ok;
    logic              w_kind_ok;
    logic              w_cc_ok;

    // Decode the incoming event
    always_comb begin
        unique case (i_status_byte[7:4])
            4'hB:    w_ev_kind = KIND_CC;
            4'hE:    w_ev_kind = KIND_BEND;
            4'hD:    w_ev_kind = KIND_PRESS;
            default: w_ev_kind = KIND_NONE;
        endcase
        if (i_status_byte >= 8'h80 && i_status_byte < 8'hF0) begin
            w_ev_chan = {1'b0, i_status_byte[3:0]} + 5'd1;
        end else begin
            w_ev_chan = '0;
        end
        case (w_ev_kind)
            KIND_CC:    w_norm = norm7(i_data_two);
            KIND_BEND:  w_norm = norm14({i_data_two, i_data_one});
            KIND_PRESS: w_norm = norm7(i_data_one);
            default:    w_norm = '0;
        endcase
    end

    assign w_in_range   = int'(i_param_index) < MAX_PARAMS;
    assign w_wr_idx     = IDX_W'(i_param_index);
    assign w_learn_take = r_learn_armed && (w_ev_kind != KIND_NONE);
    assign w_out_free   = !r_ovalid || !i_stall;

    assign w_we    = i_cmd.accept && (i_opcode == OP_SET) && w_in_range;
    assign w_re    = i_cmd.accept || i_cmd.advance;
    assign w_raddr = i_cmd.accept ? w_wr_idx : r_addr[IDX_W-1:0];

    mcmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PARAMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wr_idx),
        .i_wdata ({i_map_kind, i_map_cc_number, i_map_channel, i_device_id}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Match the entry in the check stage against the latched event
    assign {w_mk, w_mc, w_mch, w_md} = w_rdata;

    assign w_dev_ok  = (w_md == '0) ||
                       ((int'(w_md) < MAX_DEVICES) && (w_md == r_ev_dev) &&
                        (int'(r_ev_dev) < MAX_DEVICES));
    assign w_chan_ok = (w_mch == '0) || ((r_ev_chan != '0) && (r_ev_chan == w_mch));
    assign w_kind_ok = (w_mk == r_ev_kind) && (r_ev_kind != KIND_NONE);
    assign w_cc_ok   = (w_mk != KIND_CC) || (w_mc == r_ev_d1);
    assign w_match   = w_dev_ok && w_chan_ok && w_kind_ok && w_cc_ok;

    assign w_issue   = r_addr < SCAN_END;
    assign w_hit     = r_chk_v && r_valid[r_chk_idx] && w_match && (r_hits < HIT_END);
    assign w_q_found = r_q_ok && r_valid[IDX_W'(r_op_param)];

    assign o_status = '{
        learn_take: w_learn_take,
        out_free:   w_out_free,
        hit:        w_hit,
        pend_v:     r_pend_v,
        scan_done:  (r_hits == HIT_END) || (!w_issue && !r_chk_v)
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_learn_armed  <= 1'b0;
            r_learn_target <= '0;
            r_addr         <= '0;
            r_chk_v        <= 1'b0;
            r_hits         <= '0;
            r_pend_v       <= 1'b0;
            r_ovalid       <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                case (i_opcode)
                    OP_SET: begin
                        if (w_in_range) begin
                            r_valid[w_wr_idx] <= 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_in_range) begin
                            r_valid[w_wr_idx] <= 1'b0;
                        end
                    end
                    OP_CLEAR: begin
                        r_valid        <= '0;
                        r_learn_armed  <= 1'b0;
                        r_learn_target <= '0;
                    end
                    OP_LEARN: begin
                        r_learn_armed  <= 1'b1;
                        r_learn_target <= i_param_index;
                    end
                    OP_CANCEL: begin
                        r_learn_armed <= 1'b0;
                    end
                    OP_EVENT: begin
                        if (w_learn_take) begin
                            r_learn_armed  <= 1'b0;
                            r_learn_target <= '0;
                        end
                    end
                    default: ;
                endcase
                // Restart the scan on every item
                r_addr   <= '0;
                r_chk_v  <= 1'b0;
                r_hits   <= '0;
                r_pend_v <= 1'b0;
            end else if (i_cmd.advance) begin
                r_chk_v <= w_issue;
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (w_hit) begin
                    r_pend_v <= 1'b1;
                    r_hits   <= r_hits + 1'b1;
                end
            end else if (i_cmd.out_sel == OUT_PEND_LAST) begin
                r_pend_v <= 1'b0;
            end

            if (i_cmd.out_sel != OUT_NONE) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op_param <= (i_opcode == OP_EVENT) ? r_learn_target : i_param_index;
            r_q_ok     <= w_in_range;
            r_ev_kind  <= w_ev_kind;
            r_ev_chan  <= w_ev_chan;
            r_ev_d1    <= i_data_one;
            r_ev_dev   <= i_device_id;
            r_norm     <= w_norm;
        end
        if (i_cmd.advance) begin
            r_chk_idx <= r_addr[IDX_W-1:0];
            if (w_hit) begin
                r_pend_idx <= r_chk_idx;
            end
        end

        case (i_cmd.out_sel)
            OUT_QUERY: begin
                r_o_rkind <= RES_QUERY;
                r_o_param <= r_op_param;
                r_o_norm  <= '0;
                {r_o_kind, r_o_cc, r_o_chan, r_o_dev} <= w_q_found ? w_rdata : '0;
                r_o_found <= w_q_found;
                r_o_last  <= 1'b1;
            end
            OUT_LEARN: begin
                r_o_rkind <= RES_LEARN;
                r_o_param <= r_op_param;
                r_o_norm  <= '0;
                r_o_kind  <= r_ev_kind;
                r_o_cc    <= (r_ev_kind == KIND_CC) ? r_ev_d1 : '0;
                r_o_chan  <= r_ev_chan;
                r_o_dev   <= r_ev_dev;
                r_o_found <= 1'b0;
                r_o_last  <= 1'b1;
            end
            OUT_PEND_MID, OUT_PEND_LAST: begin
                r_o_rkind <= RES_UPDATE;
                r_o_param <= PIDX_W'(r_pend_idx);
                r_o_norm  <= r_norm;
                r_o_kind  <= '0;
                r_o_cc    <= '0;
                r_o_chan  <= '0;
                r_o_dev   <= '0;
                r_o_found <= 1'b0;
                r_o_last  <= (i_cmd.out_sel == OUT_PEND_LAST);
            end
            default: ;
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_result_kind   = r_o_rkind;
    assign o_out_param     = r_o_param;
    assign o_norm_value    = r_o_norm;
    assign o_out_kind      = r_o_kind;
    assign o_out_cc_number = r_o_cc;
    assign o_out_channel   = r_o_chan;
    assign o_out_device    = r_o_dev;
    assign o_found         = r_o_found;
    assign o_last          = r_o_last;

endmodule

/* rtl/core/mcmt_ctrl.sv */
module mcmt_ctrl
    import mcmt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  t_status             i_status,
    output t_cmd                o_cmd,
    output logic                o_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '{accept: 1'b0, advance: 1'b0, out_sel: OUT_NONE};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_opcode)
                        OP_QUERY: n_state = S_QUERY;
                        OP_EVENT: n_state = i_status.learn_take ? S_LEARN : S_SCAN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_QUERY: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = OUT_QUERY;
                    n_state       = S_IDLE;
                end
            end
            S_LEARN: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = OUT_LEARN;
                    n_state       = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = i_status.pend_v ? S_FLUSH : S_IDLE;
                end else if (i_status.hit && i_status.pend_v) begin
                    // A new hit proves the held one is not the last: push it out
                    if (i_status.out_free) begin
                        o_cmd.out_sel = OUT_PEND_MID;
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.out_sel = OUT_PEND_LAST;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

/* tb/sv/tb_midi_controller_mapping_table.sv */
`timescale 1ns / 1ps

module tb_midi_controller_mapping_table;
    import mcmt_pkg::*;

    localparam int N_PARAMS  = 64;
    localparam int N_FILL    = 20;
    localparam int HIT_LIMIT = 16;
    localparam int N_RANDOM  = 56;
    localparam int IDLE_WAIT = 20000;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PIDX_W-1:0]   param_index;
        logic [KIND_W-1:0]   map_kind;
        logic [CC_W-1:0]     cc;
        logic [CHAN_W-1:0]   chan;
        logic [DEV_W-1:0]    dev;
        logic [STAT_W-1:0]   status;
        logic [DATA_W-1:0]   d1;
        logic [DATA_W-1:0]   d2;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CC_W-1:0]   cc;
        logic [CHAN_W-1:0] chan;
        logic [DEV_W-1:0]  dev;
    } t_mapping;

    typedef struct packed {
        logic [RKIND_W-1:0] rkind;
        logic [PIDX_W-1:0]  param;
        logic [NORM_W-1:0]  norm;
        t_mapping           map;
        logic               found;
        logic               last;
    } t_result;

    class mapping_checker;
        bit                entry_on [N_PARAMS];
        t_mapping          entry_map [N_PARAMS];
        bit                learn_on;
        logic [PIDX_W-1:0] learn_param = '0;
        t_result           expected_results [$];
        int                errors;

        function void take_item(t_item it);
            t_result           r;
            t_mapping          m;
            logic [CHAN_W-1:0] ev_chan;
            logic [KIND_W-1:0] ev_kind;
            int unsigned       raw;
            int unsigned       value;
            int                hits;
            r     = '0;
            hits  = 0;
            value = 0;
            case (it.opcode)
                OP_SET: begin
                    entry_map[it.param_index] = '{it.map_kind, it.cc, it.chan, it.dev};
                    entry_on[it.param_index]  = 1'b1;
                end
                OP_REMOVE: entry_on[it.param_index] = 1'b0;
                OP_CLEAR: begin
                    foreach (entry_on[i]) entry_on[i] = 1'b0;
                    learn_on    = 1'b0;
                    learn_param = '0;
                end
                OP_QUERY: begin
                    r.rkind = RES_QUERY;
                    r.param = it.param_index;
                    if (entry_on[it.param_index]) begin
                        r.map   = entry_map[it.param_index];
                        r.found = 1'b1;
                    end
                    r.last = 1'b1;
                    expected_results.push_back(r);
                end
                OP_LEARN: begin
                    learn_on    = 1'b1;
                    learn_param = it.param_index;
                end
                OP_CANCEL: learn_on = 1'b0;
                OP_EVENT: begin
                    // system and data bytes carry no channel
                    ev_chan = (it.status >= 8'h80 && it.status < 8'hF0) ?
                              {1'b0, it.status[3:0]} + 5'd1 : '0;
                    ev_kind = KIND_NONE;
                    case (it.status[7:4])
                        4'hB: begin
                            ev_kind = KIND_CC;
                            raw     = 32'(it.d2);
                            value   = (raw * 65535 + 63) / 127;
                        end
                        4'hE: begin
                            ev_kind = KIND_BEND;
                            raw     = 32'({it.d2, it.d1});
                            value   = (raw * 65535 + 8191) / 16383;
                        end
                        4'hD: begin
                            ev_kind = KIND_PRESS;
                            raw     = 32'(it.d1);
                            value   = (raw * 65535 + 63) / 127;
                        end
                        default: ;
                    endcase
                    if (learn_on && ev_kind != KIND_NONE) begin
                        // capture goes out once and is not dispatched
                        r.rkind    = RES_LEARN;
                        r.param    = learn_param;
                        r.map.kind = ev_kind;
                        r.map.cc   = (ev_kind == KIND_CC) ? it.d1 : '0;
                        r.map.chan = ev_chan;
                        r.map.dev  = it.dev;
                        r.last     = 1'b1;
                        expected_results.push_back(r);
                        learn_on    = 1'b0;
                        learn_param = '0;
                    end else begin
                        for (int i = 0; i < N_PARAMS && hits < HIT_LIMIT; i++) begin
                            if (!entry_on[i]) continue;
                            m = entry_map[i];
                            if (m.dev != '0 && m.dev != it.dev) continue;
                            if (m.chan != '0 && m.chan != ev_chan) continue;
                            if (ev_kind == KIND_NONE || m.kind != ev_kind) continue;
                            if (m.kind == KIND_CC && m.cc != it.d1) continue;
                            r       = '0;
                            r.rkind = RES_UPDATE;
                            r.param = PIDX_W'(i);
                            r.norm  = NORM_W'(value);
                            expected_results.push_back(r);
                            hits++;
                        end
                        if (hits > 0) expected_results[expected_results.size() - 1].last = 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result for param %0d with nothing expected", got.param);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.rkind), 32'(got.rkind));
            compare_field("out_param", 32'(want.param), 32'(got.param));
            compare_field("norm_value", 32'(want.norm), 32'(got.norm));
            compare_field("out_kind", 32'(want.map.kind), 32'(got.map.kind));
            compare_field("out_cc_number", 32'(want.map.cc), 32'(got.map.cc));
            compare_field("out_channel", 32'(want.map.chan), 32'(got.map.chan));
            compare_field("out_device", 32'(want.map.dev), 32'(got.map.dev));
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [RKIND_W-1:0]  o_result_kind;
    logic [PIDX_W-1:0]   o_out_param;
    logic [NORM_W-1:0]   o_norm_value;
    logic [KIND_W-1:0]   o_out_kind;
    logic [CC_W-1:0]     o_out_cc_number;
    logic [CHAN_W-1:0]   o_out_channel;
    logic [DEV_W-1:0]    o_out_device;
    logic                o_found;
    logic                o_last;

    t_item          drive_item = '0;
    mapping_checker sb = new();
    int             burst_left = 0;
    int             counted_items = 0;
    int unsigned    stall_left = 0;
    int             stall_pick;

    midi_controller_mapping_table i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_opcode        (drive_item.opcode),
        .i_param_index   (drive_item.param_index),
        .i_map_kind      (drive_item.map_kind),
        .i_map_cc_number (drive_item.cc),
        .i_map_channel   (drive_item.chan),
        .i_device_id     (drive_item.dev),
        .i_status_byte   (drive_item.status),
        .i_data_one      (drive_item.d1),
        .i_data_two      (drive_item.d2),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_kind   (o_result_kind),
        .o_out_param     (o_out_param),
        .o_norm_value    (o_norm_value),
        .o_out_kind      (o_out_kind),
        .o_out_cc_number (o_out_cc_number),
        .o_out_channel   (o_out_channel),
        .o_out_device    (o_out_device),
        .o_found         (o_found),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: short random stalls mixed with long free stretches.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 9);
            if (stall_pick < 4) begin
                i_stall <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else if (stall_pick < 8) begin
                i_stall <= 1'b1;
                stall_left = $urandom_range(0, 4);
            end else begin
                i_stall <= 1'b0;
                stall_left = $urandom_range(20, 60);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.take_item(drive_item);
            if (o_valid && !i_stall) begin
                sb.check_result(t_result'{o_result_kind, o_out_param, o_norm_value,
                    t_mapping'{o_out_kind, o_out_cc_number, o_out_channel, o_out_device},
                    o_found, o_last});
            end
        end
    end

    task automatic send_item(t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        drive_item <= it;
        do @(posedge i_clk); while (o_stall);
        if (it.opcode != OP_UNUSED) counted_items++;
    endtask

    // Fields an opcode does not use carry random values.
    function automatic t_item noise_item(logic [OPCODE_W-1:0] op);
        t_item it;
        it.opcode      = op;
        it.param_index = PIDX_W'($urandom);
        it.map_kind    = KIND_W'($urandom);
        it.cc          = CC_W'($urandom);
        it.chan        = CHAN_W'($urandom);
        it.dev         = DEV_W'($urandom);
        it.status      = STAT_W'($urandom);
        it.d1          = DATA_W'($urandom);
        it.d2          = DATA_W'($urandom);
        return it;
    endfunction

    task automatic do_op(logic [OPCODE_W-1:0] op, logic [PIDX_W-1:0] idx);
        t_item it;
        it             = noise_item(op);
        it.param_index = idx;
        send_item(it);
    endtask

    task automatic do_set(logic [PIDX_W-1:0] idx, logic [KIND_W-1:0] kind,
                          logic [CC_W-1:0] cc, logic [CHAN_W-1:0] chan,
                          logic [DEV_W-1:0] dev);
        t_item it;
        it             = noise_item(OP_SET);
        it.param_index = idx;
        it.map_kind    = kind;
        it.cc          = cc;
        it.chan        = chan;
        it.dev         = dev;
        send_item(it);
    endtask

    task automatic do_event(logic [STAT_W-1:0] status, logic [DATA_W-1:0] d1,
                            logic [DATA_W-1:0] d2, logic [DEV_W-1:0] dev);
        t_item it;
        it        = noise_item(OP_EVENT);
        it.status = status;
        it.d1     = d1;
        it.d2     = d2;
        it.dev    = dev;
        send_item(it);
    endtask

    // Step the clock before the first check so the item accepted last is already in the scoreboard.
    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        burst_left = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (sb.expected_results.size() != 0 && guard < IDLE_WAIT);
    endtask

    // Small pools of controllers, channels and devices so events hit the table.
    function automatic logic [CC_W-1:0] rand_cc();
        if ($urandom_range(0, 3) == 0) return CC_W'($urandom_range(0, 127));
        return CC_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [DEV_W-1:0] rand_dev();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return '0;
        if (pick < 8) return DEV_W'($urandom_range(1, 3));
        return DEV_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [STAT_W-1:0] rand_status();
        int          fam;
        logic [3:0]  low;
        fam = $urandom_range(0, 7);
        if (fam == 7) return STAT_W'($urandom_range(0, 255));
        low = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        if (fam < 3) return {4'hB, low};
        if (fam < 5) return {4'hE, low};
        return {4'hD, low};
    endfunction

    task automatic random_step();
        int                pick;
        logic [KIND_W-1:0] kind;
        logic [CHAN_W-1:0] chan;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_NONE : KIND_W'($urandom_range(0, 2));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: chan = '0;
                9:             chan = CHAN_W'($urandom_range(0, 31));
                default:       chan = CHAN_W'($urandom_range(1, 3));
            endcase
            do_set(PIDX_W'($urandom_range(0, 63)), kind, rand_cc(), chan, rand_dev());
        end else if (pick < 60) begin
            do_event(rand_status(), rand_cc(), DATA_W'($urandom_range(0, 127)), rand_dev());
        end else if (pick < 72) begin
            do_op(OP_QUERY, PIDX_W'($urandom_range(0, 63)));
        end else if (pick < 80) begin
            do_op(OP_REMOVE, PIDX_W'($urandom_range(0, 63)));
        end else if (pick < 90) begin
            do_op(OP_LEARN, PIDX_W'($urandom_range(0, 63)));
            do_event(rand_status(), rand_cc(), DATA_W'($urandom_range(0, 127)), rand_dev());
        end else if (pick < 94) begin
            do_op(OP_LEARN, PIDX_W'($urandom_range(0, 63)));
        end else if (pick < 97) begin
            do_op(OP_CANCEL, PIDX_W'($urandom_range(0, 63)));
        end else if (pick < 99) begin
            do_op(OP_CLEAR, PIDX_W'($urandom_range(0, 63)));
        end else begin
            do_op(OP_UNUSED, PIDX_W'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        int  target;
        bit  paused;
        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the low entries with one mapping, more than the hit limit.
        for (int p = 0; p < N_FILL; p++) do_set(PIDX_W'(p), KIND_CC, '0, '0, '0);
        // all entries match: only the first sixteen report
        do_event(8'hB3, 7'd0, 7'd100, 4'd9);
        do_op(OP_CLEAR, 6'd0);

        do_op(OP_QUERY, 6'd5);
        do_set(6'd0, KIND_CC, 7'd7, 5'd0, 4'd0);
        do_set(6'd63, KIND_CC, 7'd7, 5'd1, 4'd15);
        do_set(6'd10, KIND_BEND, 7'd127, 5'd16, 4'd0);
        do_set(6'd11, KIND_PRESS, 7'd0, 5'd0, 4'd3);
        do_set(6'd12, KIND_NONE, 7'd7, 5'd0, 4'd0);
        do_set(6'd13, KIND_CC, 7'd127, 5'd31, 4'd0);
        do_op(OP_QUERY, 6'd63);
        do_op(OP_QUERY, 6'd12);
        do_event(8'hB0, 7'd7, 7'd127, 4'd15);
        do_event(8'hBF, 7'd7, 7'd0, 4'd0);
        do_event(8'hEF, 7'd127, 7'd127, 4'd5);
        do_event(8'hD2, 7'd127, 7'd0, 4'd3);
        do_event(8'h9F, 7'd7, 7'd64, 4'd0);
        do_event(8'hF8, 7'd7, 7'd0, 4'd0);
        do_event(8'h07, 7'd7, 7'd0, 4'd0);
        do_op(OP_REMOVE, 6'd0);
        do_op(OP_QUERY, 6'd0);
        // rearm replaces the target; a note leaves learn armed
        do_op(OP_LEARN, 6'd20);
        do_op(OP_LEARN, 6'd21);
        do_event(8'h90, 7'd64, 7'd64, 4'd0);
        do_event(8'hB5, 7'd64, 7'd1, 4'd9);
        do_op(OP_LEARN, 6'd30);
        do_op(OP_CANCEL, 6'd30);
        do_event(8'hD0, 7'd64, 7'd0, 4'd3);
        do_op(OP_LEARN, 6'd40);
        do_op(OP_CLEAR, 6'd40);
        do_event(8'hE4, 7'd1, 7'd2, 4'd0);
        do_op(OP_UNUSED, 6'd63);
        do_op(OP_LEARN, 6'd63);
        do_event(8'hDF, 7'd0, 7'd127, 4'd15);
        wait_idle();

        target = counted_items + N_RANDOM;
        while (counted_items < target) begin
            random_step();
            // hold the sender once until every result is back
            if (!paused && counted_items >= target - N_RANDOM / 2) begin
                paused = 1'b1;
                wait_idle();
            end
        end

        wait_idle();
        repeat (N_PARAMS + 16) @(posedge i_clk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_midi_controller_mapping_table passed");
        end else begin
            $display("tb_midi_controller_mapping_table failed");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("tb_midi_controller_mapping_table failed");
        $finish;
    end

endmodule

/* midi_controller_mapping_table.f */
+incdir+rtl/core
rtl/core/mcmt_pkg.sv
rtl/core/mcmt_ram.sv
rtl/core/mcmt_datapath.sv
rtl/core/mcmt_ctrl.sv
rtl/core/midi_controller_mapping_table.sv
tb/sv/tb_midi_controller_mapping_table.sv
